>>> rtl/vst_pkg.sv
// ----------------------------------------------------------------------------
// Viewport scroll tracker package
// Shared constants, register map, configuration type and arithmetic helpers.
// ----------------------------------------------------------------------------
package vst_pkg;

    localparam int SCREEN_WIDTH   = 256;
    localparam int SCREEN_HEIGHT  = 224;
    localparam int FOLLOW_GAIN_Q8 = 32;

    localparam int POS_W  = 25;
    localparam int TGT_W  = 17;
    localparam int WIDE_W = 40;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [TGT_W-1:0]  t_tgt;

    localparam t_wide SCR_W_Q8    = t_wide'(SCREEN_WIDTH * 256);
    localparam t_wide SCR_W_HALF  = t_wide'(SCREEN_WIDTH * 128);
    localparam t_wide SCR_H_Q8    = t_wide'(SCREEN_HEIGHT * 256);
    localparam t_wide SCR_H_HALF  = t_wide'(SCREEN_HEIGHT * 128);
    localparam t_wide GAIN_WIDE   = t_wide'(FOLLOW_GAIN_Q8);
    localparam t_wide POS_MAX     = t_wide'((1 << (POS_W - 1)) - 1);
    localparam t_wide POS_MIN     = -t_wide'(1 << (POS_W - 1));

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORLD_SIZE   = 3'd0,
        REG_ROOM_ORIGIN  = 3'd1,
        REG_ROOM_SIZE    = 3'd2,
        REG_CONTROL      = 3'd3,
        REG_LOCK_TARGET  = 3'd4,
        REG_VLOCK_ROW    = 3'd5,
        REG_DZ_EDGES     = 3'd6,
        REG_DZ_LAG       = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        VMODE_EASED    = 2'd0,
        VMODE_LOCK     = 2'd1,
        VMODE_DEADZONE = 2'd2,
        VMODE_ALT      = 2'd3
    } t_vmode;

    localparam int CTRL_ROOM_BIT    = 2;
    localparam int CTRL_LOCKED_BIT  = 3;
    localparam int CTRL_NOCLAMP_BIT = 4;

    typedef struct packed {
        logic [31:0] world_size;
        logic [31:0] room_origin;
        logic [31:0] room_size;
        logic [4:0]  control;
        logic [31:0] lock_target;
        logic [15:0] vlock_row;
        logic [15:0] dz_edges;
        logic [15:0] dz_lag;
    } t_cfg;

    function automatic t_wide f_clamp(input t_wide v, input t_wide lo, input t_wide hi);
        t_wide r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    function automatic t_wide f_ease(input t_wide cur, input t_wide goal);
        t_wide prod;
        prod = (goal - cur) * GAIN_WIDE;
        return cur + (prod >>> 8);
    endfunction

    function automatic t_wide f_clamp_axis(input t_wide v, input logic room_on,
                                           input logic [15:0] rpos,
                                           input logic [15:0] rlen,
                                           input logic [15:0] wlen,
                                           input t_wide scr_q8,
                                           input t_wide scr_half);
        t_wide r;
        t_wide lo;
        t_wide hi;
        t_wide wmax;
        r  = v;
        lo = t_wide'({rpos, 8'd0});
        hi = lo + t_wide'({rlen, 8'd0}) - scr_q8;
        if (room_on) begin
            if (hi < lo) begin
                r = lo + t_wide'({rlen, 7'd0}) - scr_half;
            end else begin
                r = f_clamp(r, lo, hi);
            end
        end
        wmax = t_wide'({wlen, 8'd0}) - scr_q8;
        if (wmax < 0) begin
            wmax = '0;
        end
        return f_clamp(r, '0, wmax);
    endfunction

endpackage

>>> rtl/vst_core.sv
// ----------------------------------------------------------------------------
// Viewport scroll tracker update logic
// Computes the next viewport origin from the current origin, the configuration and one target.
// ----------------------------------------------------------------------------
module vst_core
    import vst_pkg::*;
(
    input  t_cfg i_cfg,
    input  logic i_snap,
    input  t_tgt i_target_x,
    input  t_tgt i_target_y,
    input  t_pos i_org_x,
    input  t_pos i_org_y,
    output t_pos o_org_x,
    output t_pos o_org_y
);

    t_wide  tx;
    t_wide  ty;
    t_wide  cx;
    t_wide  cy;
    t_wide  x;
    t_wide  y;
    t_wide  top;
    t_wide  bot;
    t_wide  row;
    t_wide  want;
    t_wide  delta;
    t_wide  lag;
    t_wide  cl_x;
    t_wide  cl_y;
    t_vmode vmode;
    logic [7:0] ea;
    logic [7:0] eb;

    always_comb begin
        tx    = t_wide'(i_target_x) <<< 8;
        ty    = t_wide'(i_target_y) <<< 8;
        cx    = t_wide'(i_org_x);
        cy    = t_wide'(i_org_y);
        vmode = t_vmode'(i_cfg.control[1:0]);
        ea    = i_cfg.dz_edges[15:8];
        eb    = i_cfg.dz_edges[7:0];
        top   = (ea < eb) ? t_wide'({ea, 8'd0}) : t_wide'({eb, 8'd0});
        bot   = (ea < eb) ? t_wide'({eb, 8'd0}) : t_wide'({ea, 8'd0});
        lag   = t_wide'(i_cfg.dz_lag);
        row   = ty - cy;
        want  = cy;
        delta = '0;
        x     = cx;
        y     = cy;

        if (!i_snap && i_cfg.control[CTRL_LOCKED_BIT]) begin
            x = f_ease(cx, t_wide'({i_cfg.lock_target[31:16], 8'd0}));
            y = f_ease(cy, t_wide'({i_cfg.lock_target[15:0], 8'd0}));
        end else begin
            x = tx - SCR_W_HALF;
            case (vmode)
                VMODE_LOCK: begin
                    y = t_wide'({i_cfg.vlock_row, 8'd0});
                end
                VMODE_DEADZONE: begin
                    if (i_snap) begin
                        y = ty - ((top + bot) >>> 1);
                    end else begin
                        if (row < top) begin
                            want = ty - top;
                        end else if (row > bot) begin
                            want = ty - bot;
                        end
                        delta = want - cy;
                        if (lag == '0) begin
                            y = want;
                        end else if (delta <= lag && -delta <= lag) begin
                            y = want;
                        end else if (delta > 0) begin
                            y = cy + lag;
                        end else begin
                            y = cy - lag;
                        end
                    end
                end
                default: begin
                    want = ty - SCR_H_HALF;
                    y    = i_snap ? want : f_ease(cy, want);
                end
            endcase
        end

        cl_x = x;
        cl_y = y;
        if (!i_cfg.control[CTRL_NOCLAMP_BIT]) begin
            cl_x = f_clamp_axis(x, i_cfg.control[CTRL_ROOM_BIT],
                                i_cfg.room_origin[31:16], i_cfg.room_size[31:16],
                                i_cfg.world_size[31:16], SCR_W_Q8, SCR_W_HALF);
            cl_y = f_clamp_axis(y, i_cfg.control[CTRL_ROOM_BIT],
                                i_cfg.room_origin[15:0], i_cfg.room_size[15:0],
                                i_cfg.world_size[15:0], SCR_H_Q8, SCR_H_HALF);
        end
    end

    assign o_org_x = t_pos'(f_clamp(cl_x, POS_MIN, POS_MAX));
    assign o_org_y = t_pos'(f_clamp(cl_y, POS_MIN, POS_MAX));

endmodule

>>> rtl/viewport_scroll_tracker.sv
// ----------------------------------------------------------------------------
// Viewport scroll tracker
// Keeps a Q16.8 viewport origin that follows a target point once per frame.
//
// The slave stream carries one target per word, with the snap flag on tuser.
// Each accepted word yields exactly one master word holding the new origin.
// A word is captured in an input register, the update is computed from it
// combinationally and stored in the origin register, which also drives the
// master stream, when that register is empty or its word is being taken.
// Throughput is one word per cycle while the receiver does not stall: the
// input register refills in the same cycle its word moves to the output, so
// the rate is set by the single update stage between the two registers.
// When the receiver stalls, the result holds and one more word can wait in
// the input register; after that the slave tready drops.
// The configuration channel is always ready and should be written while the
// block is idle. Reset clears the configuration, the valid flags and the
// origin to zero.
// ----------------------------------------------------------------------------
module viewport_scroll_tracker
    import vst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [39:0]          i_s_axis_tdata,  // target_x[16:0], target_y[33:17]
    input  logic                 i_s_axis_tuser,  // mode (snap)
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [55:0]          o_m_axis_tdata,  // view_x[24:0], view_y[49:25]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic r_in_valid;
    logic r_snap;
    t_tgt r_tx;
    t_tgt r_ty;
    logic r_out_valid;
    t_pos r_org_x;
    t_pos r_org_y;
    t_pos n_org_x;
    t_pos n_org_y;
    logic fire;
    logic in_take;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WORLD_SIZE:  r_cfg.world_size  <= i_cfg_data;
                REG_ROOM_ORIGIN: r_cfg.room_origin <= i_cfg_data;
                REG_ROOM_SIZE:   r_cfg.room_size   <= i_cfg_data;
                REG_CONTROL:     r_cfg.control     <= i_cfg_data[4:0];
                REG_LOCK_TARGET: r_cfg.lock_target <= i_cfg_data;
                REG_VLOCK_ROW:   r_cfg.vlock_row   <= i_cfg_data[15:0];
                REG_DZ_EDGES:    r_cfg.dz_edges    <= i_cfg_data[15:0];
                REG_DZ_LAG:      r_cfg.dz_lag      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_snap <= i_s_axis_tuser;
            r_tx   <= i_s_axis_tdata[16:0];
            r_ty   <= i_s_axis_tdata[33:17];
        end
    end

    vst_core u_core (
        .i_cfg      (r_cfg),
        .i_snap     (r_snap),
        .i_target_x (r_tx),
        .i_target_y (r_ty),
        .i_org_x    (r_org_x),
        .i_org_y    (r_org_y),
        .o_org_x    (n_org_x),
        .o_org_y    (n_org_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_org_x     <= n_org_x;
                r_org_y     <= n_org_y;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_org_y, r_org_x};

endmodule
